// File: design/b2d_pkg.sv
package b2d_pkg;

  localparam int unsigned ValueW    = 64;
  localparam int unsigned NumDigits = 20;
  localparam int unsigned BcdW      = 4 * NumDigits;
  localparam int unsigned CharW     = 6;
  localparam int unsigned BitCntW   = $clog2(ValueW);
  localparam int unsigned DigCntW   = $clog2(NumDigits);

  localparam logic [CharW-1:0]   AsciiZero = CharW'(8'h30);
  localparam logic [3:0]         DecMax    = 4'd9;
  localparam logic [BitCntW-1:0] LastBit   = BitCntW'(ValueW - 1);
  localparam logic [DigCntW-1:0] LastDigit = DigCntW'(NumDigits - 1);

  typedef struct packed {
    logic            valid;
    logic [BcdW-1:0] bcd;
  } b2d_xfer_t;

  // add-3 correction on every digit of five or more
  function automatic logic [BcdW-1:0] bcd_adjust(input logic [BcdW-1:0] b);
    logic [BcdW-1:0] r;
    r = b;
    for (int i = 0; i < NumDigits; i++) begin
      if (b[4*i +: 4] >= 4'd5) begin
        r[4*i +: 4] = b[4*i +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  function automatic logic bcd_valid(input logic [BcdW-1:0] b);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < NumDigits; i++) begin
      if (b[4*i +: 4] > DecMax) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

// File: design/b2d_if.sv
interface b2d_in_if;
  import b2d_pkg::*;
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface b2d_out_if;
  import b2d_pkg::*;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] ascii_char;
  logic             last;
  modport source (output valid, output ascii_char, output last, input ready);
  modport sink   (input valid, input ascii_char, input last, output ready);
endinterface

// File: design/b2d_dabble.sv
module b2d_dabble
  import b2d_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [ValueW-1:0] value_i,
  output logic              in_ready_o,
  output b2d_xfer_t         xfer_o,
  input  logic              xfer_ready_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_HOLD
  } state_e;

  state_e               state_q, state_d;
  logic [BitCntW-1:0]   cnt_q, cnt_d;
  logic [ValueW-1:0]    bin_q, bin_d;
  logic [BcdW-1:0]      bcd_q, bcd_d;
  logic [BcdW-1:0]      bcd_adj;

  assign in_ready_o   = (state_q == S_IDLE);
  assign xfer_o.valid = (state_q == S_HOLD);
  assign xfer_o.bcd   = bcd_q;
  assign bcd_adj      = bcd_adjust(bcd_q);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          bin_d   = value_i;
          bcd_d   = '0;
          cnt_d   = '0;
          state_d = S_CONV;
        end
      end
      S_CONV: begin
        bcd_d = {bcd_adj[BcdW-2:0], bin_q[ValueW-1]};
        bin_d = {bin_q[ValueW-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastBit) begin
          cnt_d   = '0;
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (xfer_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  a_idle_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_CONV |-> cnt_q == '0)
    else $error("bit counter not cleared outside conversion");

  a_conv_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CONV && cnt_q == LastBit) |=> state_q == S_HOLD)
    else $error("conversion did not end after the last bit");

  a_bcd_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_HOLD |-> bcd_valid(bcd_q))
    else $error("invalid BCD digit after conversion");

endmodule

// File: design/b2d_emit.sv
module b2d_emit
  import b2d_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  b2d_xfer_t        xfer_i,
  output logic             xfer_ready_o,
  output logic             out_valid_o,
  output logic [CharW-1:0] ascii_char_o,
  output logic             last_o,
  input  logic             out_ready_i
);

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_e;

  state_e             state_q, state_d;
  logic [BcdW-1:0]    dig_q, dig_d;
  logic [DigCntW-1:0] pos_q, pos_d;
  logic               started_q, started_d;
  logic               ov_q, ov_d;
  logic [CharW-1:0]   char_q, char_d;
  logic               last_q, last_d;

  logic [3:0] top_dig;
  logic       step;
  logic       at_last;

  assign xfer_ready_o = (state_q == S_IDLE);
  assign top_dig      = dig_q[BcdW-1 -: 4];
  assign at_last      = (pos_q == LastDigit);
  assign step         = (state_q == S_EMIT) && (!ov_q || out_ready_i);

  always_comb begin
    state_d   = state_q;
    dig_d     = dig_q;
    pos_d     = pos_q;
    started_d = started_q;
    ov_d      = ov_q && !out_ready_i;
    char_d    = char_q;
    last_d    = last_q;
    case (state_q)
      S_IDLE: begin
        if (xfer_i.valid) begin
          dig_d     = xfer_i.bcd;
          pos_d     = '0;
          started_d = 1'b0;
          state_d   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (step) begin
          // leading zeros are dropped; the units digit always goes out
          if (top_dig != 4'd0 || started_q || at_last) begin
            ov_d      = 1'b1;
            char_d    = AsciiZero | CharW'(top_dig);
            last_d    = at_last;
            started_d = 1'b1;
          end
          dig_d = {dig_q[BcdW-5:0], 4'd0};
          pos_d = pos_q + 1'b1;
          if (at_last) begin
            pos_d   = '0;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pos_q     <= '0;
      started_q <= 1'b0;
      ov_q      <= 1'b0;
      dig_q     <= '0;
      char_q    <= AsciiZero;
      last_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      started_q <= started_d;
      ov_q      <= ov_d;
      dig_q     <= dig_d;
      char_q    <= char_d;
      last_q    <= last_d;
    end
  end

  assign out_valid_o  = ov_q;
  assign ascii_char_o = char_q;
  assign last_o       = last_q;

  a_char_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (char_q[CharW-1:4] == AsciiZero[CharW-1:4] && char_q[3:0] <= DecMax))
    else $error("item is not a decimal digit");

  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && at_last) |=> (state_q == S_IDLE && ov_q && last_q))
    else $error("run did not close with a last item");

  a_idle_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> pos_q == '0)
    else $error("digit position not cleared when idle");

endmodule

// File: design/binary_to_decimal_ascii_top.sv
// Binary to decimal ASCII converter, 64-bit unsigned.
// in_i : one item per number, value[63:0]; taken when valid and ready.
// out_o: one item per decimal digit, ascii_char = 0x30..0x39, most
//        significant first, leading zeros dropped; last marks the units
//        digit. Zero gives the single item '0' with last set.
// Timing: the double-dabble unit shifts one input bit per cycle through
// the whole input word once the item is taken. The digit emitter then
// walks the 20 BCD digits one per cycle while the output is not stalled,
// skipping leading zeros; once the first character appears, the rest
// follow one per cycle while out_o.ready is high.
// Overlap: the next number is taken the cycle after the previous BCD word
// is handed to the emitter, so the conversion of one number overlaps the
// output of the one before.
// Stall: the output register holds its item while out_o.ready is low and
// the emitter waits; nothing is lost or repeated.
// Reset: asynchronous, active low; both units return to idle and any
// item in flight is dropped. No state is kept between items.
module binary_to_decimal_ascii_top
  import b2d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  b2d_in_if.sink     in_i,
  b2d_out_if.source  out_o
);

  b2d_xfer_t xfer;
  logic      xfer_ready;

  b2d_dabble u_dabble (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .value_i      (in_i.value),
    .in_ready_o   (in_i.ready),
    .xfer_o       (xfer),
    .xfer_ready_i (xfer_ready)
  );

  b2d_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .xfer_i       (xfer),
    .xfer_ready_o (xfer_ready),
    .out_valid_o  (out_o.valid),
    .ascii_char_o (out_o.ascii_char),
    .last_o       (out_o.last),
    .out_ready_i  (out_o.ready)
  );

endmodule
